/* src/egcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types and constants for the extended gcd / modular inverse unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

   localparam int OPERAND_WIDTH = 31;
   localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH + 1);

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] first_operand;
      logic [OPERAND_WIDTH-1:0] second_operand;
   } req_payload_type;

   typedef struct packed {
      logic [OPERAND_WIDTH-1:0]        divisor;
      logic signed [COEF_WIDTH-1:0]    coef_first;
      logic signed [COEF_WIDTH-1:0]    coef_second;
      logic [OPERAND_WIDTH-1:0]        inverse;
      logic                            has_inverse;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FIX,
      ST_MOD,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

/* src/egcd_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_divider
// Restoring radix-2 divider, one quotient bit per cycle. The quotient bits
// are folded into two shift-add accumulators so that q*ms and q*mt come out
// with the remainder, modulo 2^COEF_WIDTH.
// ----------------------------------------------------------------------------
module egcd_divider
   import egcd_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  div_cmd_type              div_cmd,
   input  wire  [COEF_WIDTH-1:0]    dividend,
   input  wire  [OPERAND_WIDTH-1:0] divisor,
   input  wire  [COEF_WIDTH-1:0]    mul_s,
   input  wire  [COEF_WIDTH-1:0]    mul_t,
   output div_stat_type             div_stat,
   output logic [OPERAND_WIDTH-1:0] remainder,
   output logic [COEF_WIDTH-1:0]    prod_s,
   output logic [COEF_WIDTH-1:0]    prod_t
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [COEF_WIDTH-1:0]    dq_ff, dq_in;
   logic [OPERAND_WIDTH-1:0] dvs_ff, dvs_in;
   logic [COEF_WIDTH-1:0]    ms_ff, ms_in;
   logic [COEF_WIDTH-1:0]    mt_ff, mt_in;
   logic [COEF_WIDTH-1:0]    ps_ff, ps_in;
   logic [COEF_WIDTH-1:0]    pt_ff, pt_in;

   logic [COEF_WIDTH-1:0]    rem_shift;
   logic [COEF_WIDTH-1:0]    rem_sub;
   logic                     qbit;

   always_comb begin
      rem_shift = {rem_ff, dq_ff[COEF_WIDTH-1]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      qbit      = (rem_shift >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      ms_in   = ms_ff;
      mt_in   = mt_ff;
      ps_in   = ps_ff;
      pt_in   = pt_ff;

      if (div_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dq_in   = dividend;
         dvs_in  = divisor;
         ms_in   = mul_s;
         mt_in   = mul_t;
         ps_in   = '0;
         pt_in   = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops out
         rem_in = qbit ? rem_sub[OPERAND_WIDTH-1:0] : rem_shift[OPERAND_WIDTH-1:0];
         dq_in  = {dq_ff[COEF_WIDTH-2:0], 1'b0};
         ps_in  = {ps_ff[COEF_WIDTH-2:0], 1'b0} + (qbit ? ms_ff : '0);
         pt_in  = {pt_ff[COEF_WIDTH-2:0], 1'b0} + (qbit ? mt_ff : '0);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(COEF_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
      ms_ff  <= ms_in;
      mt_ff  <= mt_in;
      ps_ff  <= ps_in;
      pt_ff  <= pt_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign remainder     = rem_ff;
   assign prod_s        = ps_ff;
   assign prod_t        = pt_ff;

endmodule

`default_nettype wire

/* src/extended_gcd_modular_inverse_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// extended_gcd_modular_inverse_unit
// Extended Euclid: gcd, Bezout coefficients and inverse of the second
// operand modulo the first, on one shared serial divider.
//
//   channel  direction  ports                            transaction
//   req      in         req_valid/req_ready/req_payload  operands a, b
//   rsp      out        rsp_valid/rsp_ready/rsp_payload  gcd, s, t, inverse
//
// Each Euclid step is a check and a serial division, one quotient bit per
// cycle, whose result updates remainders and coefficients. A final division
// reduces t modulo the first operand only when an inverse exists; at most 46
// Euclid steps are taken for 31-bit operands.
// req_ready is high only in idle; a new transaction can be taken while the
// previous result still waits on rsp. Reset is synchronous; a result held by
// rsp_ready low stalls the unit before it writes the next result.
// ----------------------------------------------------------------------------
module extended_gcd_modular_inverse_unit
   import egcd_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  wire             rsp_ready,
   output rsp_payload_type rsp_payload
);

   state_type state_ff, state_in;

   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] r1_ff, r1_in;
   logic [OPERAND_WIDTH-1:0] r2_ff, r2_in;
   logic [COEF_WIDTH-1:0]    s1_ff, s1_in;
   logic [COEF_WIDTH-1:0]    s2_ff, s2_in;
   logic [COEF_WIDTH-1:0]    t1_ff, t1_in;
   logic [COEF_WIDTH-1:0]    t2_ff, t2_in;
   logic                     ok_ff, ok_in;
   logic                     neg_ff, neg_in;
   logic [OPERAND_WIDTH-1:0] inv_ff, inv_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   div_cmd_type              div_cmd;
   div_stat_type             div_stat;
   logic [COEF_WIDTH-1:0]    div_dividend;
   logic [OPERAND_WIDTH-1:0] div_divisor;
   logic [OPERAND_WIDTH-1:0] div_rem;
   logic [COEF_WIDTH-1:0]    div_prod_s;
   logic [COEF_WIDTH-1:0]    div_prod_t;

   logic                     out_free;
   logic [COEF_WIDTH-1:0]    t1_mag;

   egcd_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_cmd   (div_cmd),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .mul_s     (s2_ff),
      .mul_t     (t2_ff),
      .div_stat  (div_stat),
      .remainder (div_rem),
      .prod_s    (div_prod_s),
      .prod_t    (div_prod_t)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign t1_mag   = '0 - t1_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: state_in = (r2_ff == '0) ? ST_FIX : ST_DIV;
         ST_DIV:   if (div_stat.done) state_in = ST_CHECK;
         ST_FIX:   state_in = (r1_ff == OPERAND_WIDTH'(1) && a_ff != '0) ? ST_MOD : ST_OUT;
         ST_MOD:   if (div_stat.done) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = 1'b0;
      div_cmd.start = 1'b0;
      div_dividend  = {1'b0, r1_ff};
      div_divisor   = r2_ff;

      a_in   = a_ff;
      r1_in  = r1_ff;
      r2_in  = r2_ff;
      s1_in  = s1_ff;
      s2_in  = s2_ff;
      t1_in  = t1_ff;
      t2_in  = t2_ff;
      ok_in  = ok_ff;
      neg_in = neg_ff;
      inv_in = inv_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            a_in  = req_payload.first_operand;
            r1_in = req_payload.first_operand;
            r2_in = req_payload.second_operand;
            s1_in = COEF_WIDTH'(1);
            s2_in = '0;
            t1_in = '0;
            t2_in = COEF_WIDTH'(1);
         end
         ST_CHECK: begin
            div_cmd.start = (r2_ff != '0);
         end
         ST_DIV: begin
            if (div_stat.done) begin
               r1_in = r2_ff;
               r2_in = div_rem;
               s1_in = s2_ff;
               s2_in = s1_ff - div_prod_s;
               t1_in = t2_ff;
               t2_in = t1_ff - div_prod_t;
            end
         end
         ST_FIX: begin
            ok_in  = (r1_ff == OPERAND_WIDTH'(1)) && (a_ff != '0);
            neg_in = t1_ff[COEF_WIDTH-1];
            inv_in = '0;
            div_dividend  = t1_ff[COEF_WIDTH-1] ? t1_mag : t1_ff;
            div_divisor   = a_ff;
            div_cmd.start = ok_in;
         end
         ST_MOD: begin
            if (div_stat.done) begin
               if (neg_ff && div_rem != '0) inv_in = a_ff - div_rem;
               else                         inv_in = div_rem;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.divisor     = r1_ff;
               rsp_payload_in.coef_first  = s1_ff;
               rsp_payload_in.coef_second = t1_ff;
               rsp_payload_in.inverse     = ok_ff ? inv_ff : '0;
               rsp_payload_in.has_inverse = ok_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff           <= a_in;
      r1_ff          <= r1_in;
      r2_ff          <= r2_in;
      s1_ff          <= s1_in;
      s2_ff          <= s2_in;
      t1_ff          <= t1_in;
      t2_ff          <= t2_in;
      ok_ff          <= ok_in;
      neg_ff         <= neg_in;
      inv_ff         <= inv_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // divider is never restarted mid-division
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a division finishes only in a state that consumes it
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV || state_ff == ST_MOD))
      else $error("divider result in unexpected state");

   // no new transaction taken while the divider is working
   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_stat.busy)
      else $error("request accepted during division");

   // a result without inverse carries a zero inverse field
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.has_inverse) |-> (rsp_payload.inverse == '0))
      else $error("inverse field nonzero without inverse");

endmodule

`default_nettype wire
